// ===== src/phts_pkg.sv =====
// package for the prime hash table sizer
// shared widths, constants and item payload types; no dependencies
package phts_pkg;
	localparam int MAX_ENTRIES = 4096;
	localparam int IDX_W = $clog2(MAX_ENTRIES);
	localparam int CNT_W = IDX_W + 1;
	localparam int HASH_W = 32;
	localparam int DIV_W = 8;

	typedef struct packed {
		logic [HASH_W-1:0] entry_hash;
		logic              is_last;
	} in_item_t;

	typedef struct packed {
		logic [CNT_W-1:0] bucket_count;
		logic [CNT_W-1:0] empty_buckets;
		logic             low_fill;
		logic             overflowed;
	} out_item_t;
endpackage

// ===== src/phts_if.sv =====
// valid/ready channel interfaces for input and result items
// depends on phts_pkg
interface phts_in_if;
	logic              valid;
	logic              ready;
	phts_pkg::in_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface phts_out_if;
	logic               valid;
	logic               ready;
	phts_pkg::out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== src/phts_mod.sv =====
// shared remainder unit: restoring division, one quotient bit per cycle
// depends on phts_pkg
module phts_mod (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [phts_pkg::HASH_W-1:0]  dividend,
	input  logic [phts_pkg::CNT_W-1:0]   divisor,
	output logic                         done,
	output logic [phts_pkg::CNT_W-1:0]   rem
);
	localparam int STEP_W = $clog2(phts_pkg::HASH_W + 1);

	logic                        busy_q;
	logic                        done_q;
	logic [STEP_W-1:0]           step_q;
	logic [phts_pkg::HASH_W-1:0] dvd_q;
	logic [phts_pkg::CNT_W-1:0]  dvs_q;
	logic [phts_pkg::CNT_W-1:0]  rem_q;
	logic [phts_pkg::CNT_W:0]    shifted;

	assign shifted = {rem_q, dvd_q[phts_pkg::HASH_W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(phts_pkg::HASH_W);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// partial remainder stays below the divisor, so its low bits are enough
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= dvd_q << 1;
			if (shifted >= {1'b0, dvs_q}) rem_q <= shifted[phts_pkg::CNT_W-1:0] - dvs_q;
			else rem_q <= shifted[phts_pkg::CNT_W-1:0];
		end
	end

	assign done = done_q;
	assign rem = rem_q;

`ifndef SYNTHESIS
	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (rem < dvs_q)) else $error("remainder not below divisor");
	a_no_restart_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !start) else $error("remainder unit restarted while busy");
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy_q)) else $error("done without a running division");
`endif
endmodule

// ===== src/prime_hash_table_sizer_unit.sv =====
// prime hash table sizer: loads hashes one item per cycle, then sizes the table
// sizing: runs after the last item; each trial clears the bucket map, marks
//   the bucket of every stored hash through the shared 32-step remainder unit,
//   then counts empty buckets; each trial divisor of the prime search also uses it
// throughput: one non-last item per cycle; a last item holds ready low until
//   its result is registered
// reset: arst_n clears the sequencer, entry count, flags and output valid;
//   the bucket map is cleared at the start of every trial, so no reset pass
// depends on phts_pkg, phts_if, phts_mod
module prime_hash_table_sizer_unit (
	input  logic       clk,
	input  logic       arst_n,
	phts_in_if.sink    item_in,
	phts_out_if.source result_out
);
	localparam int IW = phts_pkg::IDX_W;
	localparam int CW = phts_pkg::CNT_W;
	localparam int DW = phts_pkg::DIV_W;
	localparam int SQ_W = 2 * DW;

	typedef enum logic [3:0] {
		S_IDLE, S_PF_TEST, S_PF_DIV, S_APPLY, S_CLR, S_MARK_RD, S_MARK_GO,
		S_MARK_DIV, S_CNT_RD, S_CNT_ACC, S_CHECK, S_DONE
	} state_t;

	state_t         state_q;
	logic [CW-1:0]  count_q;      // stored hashes, 0..MAX_ENTRIES
	logic           ovf_q;
	logic [CW-1:0]  n_q;          // set size frozen at the last item
	logic [CW-1:0]  floor_q;      // max(n/2, 1)
	logic [CW-1:0]  size_q;
	logic [CW-1:0]  cand_q;       // prime search candidate
	logic [DW-1:0]  div_q;        // trial divisor, odd from 3
	logic           init_q;       // first prime search of a set
	logic [CW-1:0]  idx_q;
	logic [CW-1:0]  empty_q;
	logic           low_q;
	logic           out_valid_q;
	phts_pkg::out_item_t out_q;

	// memories
	logic [phts_pkg::HASH_W-1:0] hash_store [phts_pkg::MAX_ENTRIES];
	logic                        bucket_used [phts_pkg::MAX_ENTRIES];
	logic [phts_pkg::HASH_W-1:0] store_rd_q;
	logic                        bkt_rd_q;

	logic           accept;
	logic           mod_start;
	logic [phts_pkg::HASH_W-1:0] mod_dvd;
	logic [CW-1:0]  mod_dvs;
	logic           mod_done;
	logic [CW-1:0]  mod_rem;
	logic [SQ_W-1:0] div_sq;
	logic           bkt_we;
	logic [IW-1:0]  bkt_waddr;
	logic           bkt_wdata;
	logic [CW-1:0]  n_next;
	logic [CW-1:0]  shrunk;
	logic           out_free;

	assign item_in.ready = (state_q == S_IDLE);
	assign accept = item_in.valid && item_in.ready;
	assign out_free = !out_valid_q || result_out.ready;
	assign div_sq = div_q * div_q;

	// count after storing the current item, if there is room
	assign n_next = (count_q < CW'(phts_pkg::MAX_ENTRIES)) ? count_q + 1'b1 : count_q;
	assign shrunk = (cand_q > floor_q) ? cand_q : floor_q;

	// operands for the shared remainder unit: prime test or bucket index
	always_comb begin
		mod_start = 1'b0;
		mod_dvd = store_rd_q;
		mod_dvs = size_q;
		if (state_q == S_PF_TEST && cand_q >= CW'(4) && cand_q[0] &&
		    div_sq <= SQ_W'(cand_q)) begin
			mod_start = 1'b1;
			mod_dvd = phts_pkg::HASH_W'(cand_q);
			mod_dvs = CW'(div_q);
		end else if (state_q == S_MARK_GO) begin
			mod_start = 1'b1;
		end
	end

	// bucket map writes: clear sweep or mark
	always_comb begin
		bkt_we = 1'b0;
		bkt_waddr = idx_q[IW-1:0];
		bkt_wdata = 1'b0;
		if (state_q == S_CLR) begin
			bkt_we = 1'b1;
		end else if (state_q == S_MARK_DIV && mod_done) begin
			bkt_we = 1'b1;
			bkt_waddr = mod_rem[IW-1:0];
			bkt_wdata = 1'b1;
		end
	end

	phts_mod u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mod_start),
		.dividend (mod_dvd),
		.divisor  (mod_dvs),
		.done     (mod_done),
		.rem      (mod_rem)
	);

	always_ff @(posedge clk) begin
		if (accept && count_q < CW'(phts_pkg::MAX_ENTRIES))
			hash_store[count_q[IW-1:0]] <= item_in.data.entry_hash;
		store_rd_q <= hash_store[idx_q[IW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (bkt_we) bucket_used[bkt_waddr] <= bkt_wdata;
		bkt_rd_q <= bucket_used[idx_q[IW-1:0]];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			ovf_q <= 1'b0;
			out_valid_q <= 1'b0;
			size_q <= '0;
			low_q <= 1'b0;
			init_q <= 1'b0;
			idx_q <= '0;
			empty_q <= '0;
			n_q <= '0;
			floor_q <= '0;
			cand_q <= '0;
			div_q <= '0;
			out_q <= '0;
		end else begin
			// result taken; a new one from S_DONE is set below instead
			if (out_valid_q && result_out.ready && state_q != S_DONE)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						count_q <= n_next;
						if (count_q >= CW'(phts_pkg::MAX_ENTRIES)) ovf_q <= 1'b1;
						if (item_in.data.is_last) begin
							n_q <= n_next;
							floor_q <= (n_next >> 1) > CW'(1) ? n_next >> 1 : CW'(1);
							cand_q <= n_next;
							div_q <= DW'(3);
							init_q <= 1'b1;
							low_q <= 1'b0;
							empty_q <= '0;
							state_q <= S_PF_TEST;
						end
					end
				end
				S_PF_TEST: begin
					if (cand_q < CW'(4)) begin
						state_q <= S_APPLY;
					end else if (!cand_q[0]) begin
						cand_q <= cand_q - 1'b1;
					end else if (mod_start) begin
						state_q <= S_PF_DIV;
					end else begin
						state_q <= S_APPLY;
					end
				end
				S_PF_DIV: begin
					if (mod_done) begin
						if (mod_rem == '0) begin
							cand_q <= cand_q - 1'b1;
							div_q <= DW'(3);
						end else begin
							div_q <= div_q + DW'(2);
						end
						state_q <= S_PF_TEST;
					end
				end
				S_APPLY: begin
					idx_q <= '0;
					if (init_q) begin
						size_q <= cand_q;
						state_q <= S_CLR;
					end else if (shrunk >= size_q) begin
						// no smaller size left above the floor
						low_q <= 1'b1;
						state_q <= S_DONE;
					end else begin
						size_q <= shrunk;
						state_q <= S_CLR;
					end
				end
				S_CLR: begin
					if (idx_q == size_q - 1'b1) begin
						idx_q <= '0;
						state_q <= S_MARK_RD;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_MARK_RD: state_q <= S_MARK_GO;
				S_MARK_GO: state_q <= S_MARK_DIV;
				S_MARK_DIV: begin
					if (mod_done) begin
						if (idx_q == n_q - 1'b1) begin
							idx_q <= '0;
							empty_q <= '0;
							state_q <= S_CNT_RD;
						end else begin
							idx_q <= idx_q + 1'b1;
							state_q <= S_MARK_RD;
						end
					end
				end
				S_CNT_RD: state_q <= S_CNT_ACC;
				S_CNT_ACC: begin
					if (!bkt_rd_q) empty_q <= empty_q + 1'b1;
					if (idx_q == size_q - 1'b1) begin
						state_q <= S_CHECK;
					end else begin
						idx_q <= idx_q + 1'b1;
						state_q <= S_CNT_RD;
					end
				end
				S_CHECK: begin
					if (empty_q <= (size_q >> 2)) begin
						state_q <= S_DONE;
					end else begin
						cand_q <= size_q - (size_q >> 2);
						div_q <= DW'(3);
						init_q <= 1'b0;
						state_q <= S_PF_TEST;
					end
				end
				S_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_q.bucket_count <= size_q;
						out_q.empty_buckets <= empty_q;
						out_q.low_fill <= low_q;
						out_q.overflowed <= ovf_q;
						count_q <= '0;
						ovf_q <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign result_out.valid = out_valid_q;
	assign result_out.data = out_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(phts_pkg::MAX_ENTRIES)) else $error("entry count past capacity");
	a_size_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		result_out.valid |-> (result_out.data.bucket_count != '0))
		else $error("zero table size reported");
	a_trial_size: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLR) |-> (size_q != '0 && size_q <= n_q))
		else $error("trial size out of range");
	a_result_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && out_free) |=> out_valid_q)
		else $error("result not registered");
`endif
endmodule
